// ----- design/tmcbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tmcbs_pkg
// Types, constants and format decode for the mip chain byte size unit.
// ----------------------------------------------------------------------------
package tmcbs_pkg;

    localparam int MAX_DIM_LOG2 = 13;
    localparam int DIM_W        = 14;
    localparam int FMT_W        = 5;
    localparam int SUM_W        = DIM_W + 2;
    localparam int MUL_A_W      = 2 * DIM_W;
    localparam int MUL_B_W      = DIM_W;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int TOTAL_W      = 48;
    localparam int OUT_W        = 32;
    localparam int SHIFT_W      = 3;

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1 << MAX_DIM_LOG2);

    // format codes
    localparam logic [FMT_W-1:0] FMT_DXT1        = 5'd0;
    localparam logic [FMT_W-1:0] FMT_DXT3        = 5'd1;
    localparam logic [FMT_W-1:0] FMT_DXT5        = 5'd2;
    localparam logic [FMT_W-1:0] FMT_RGBA16_LO   = 5'd3;
    localparam logic [FMT_W-1:0] FMT_RGBA16_HI   = 5'd4;
    localparam logic [FMT_W-1:0] FMT_TEX32_LO    = 5'd5;
    localparam logic [FMT_W-1:0] FMT_TEX32_HI    = 5'd11;
    localparam logic [FMT_W-1:0] FMT_TEX16_LO    = 5'd12;
    localparam logic [FMT_W-1:0] FMT_TEX16_HI    = 5'd14;
    localparam logic [FMT_W-1:0] FMT_TEX8_LO     = 5'd15;
    localparam logic [FMT_W-1:0] FMT_TEX8_HI     = 5'd16;

    typedef enum logic [1:0] {
        KIND_UNKNOWN,
        KIND_BLOCK,
        KIND_TEXEL
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SHIFT_W-1:0] shift;   // log2 of bytes per block or texel
    } t_fmt_info;

    function automatic t_fmt_info fmt_decode(input logic [FMT_W-1:0] fmt);
        t_fmt_info info;
        info.kind  = KIND_UNKNOWN;
        info.shift = '0;
        case (fmt) inside
            FMT_DXT1: begin
                info.kind  = KIND_BLOCK;
                info.shift = SHIFT_W'(3);
            end
            FMT_DXT3, FMT_DXT5: begin
                info.kind  = KIND_BLOCK;
                info.shift = SHIFT_W'(4);
            end
            [FMT_RGBA16_LO:FMT_RGBA16_HI]: begin
                info.kind  = KIND_TEXEL;
                info.shift = SHIFT_W'(3);
            end
            [FMT_TEX32_LO:FMT_TEX32_HI]: begin
                info.kind  = KIND_TEXEL;
                info.shift = SHIFT_W'(2);
            end
            [FMT_TEX16_LO:FMT_TEX16_HI]: begin
                info.kind  = KIND_TEXEL;
                info.shift = SHIFT_W'(1);
            end
            [FMT_TEX8_LO:FMT_TEX8_HI]: begin
                info.kind  = KIND_TEXEL;
                info.shift = SHIFT_W'(0);
            end
            default: begin
                info.kind  = KIND_UNKNOWN;
                info.shift = '0;
            end
        endcase
        return info;
    endfunction

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    function automatic logic [DIM_W-1:0] dim_halve(input logic [DIM_W-1:0] v);
        return (v[DIM_W-1:1] == '0) ? DIM_W'(1) : (v >> 1);
    endfunction

    // blocks per row or column: ceil(v / 4)
    function automatic logic [DIM_W-1:0] dim_blocks(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] s;
        s = {1'b0, v} + (DIM_W+1)'(3);
        return DIM_W'(s[DIM_W:2]);
    endfunction

endpackage

// ----- design/texture_mip_chain_byte_size_unit.sv -----
// ----------------------------------------------------------------------------
// texture_mip_chain_byte_size_unit
// Memory footprint in bytes of a texture's mip chain, with cube and overflow.
// ----------------------------------------------------------------------------
// One texture description is taken per beat and one result beat follows. A
// single 28x14 multiplier is shared under a small sequencer: each mip level
// runs height times width, then times depth, then accumulate. The number
// of levels counted is 1 with mips off, up to 14 for an 8192 base. Once the
// last level is accumulated, the result beat is registered in S_FINISH; for
// an unknown format it is offered on the cycle right after the accepting
// edge. The next texture is taken only once the result beat has been taken
// and the sequencer is back in S_IDLE, so a new texture is never accepted
// while one is in flight. o_ready is low from accept until the result
// beat is taken.
module texture_mip_chain_byte_size_unit
    import tmcbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FMT_W-1:0]    i_pixel_format,
    input  logic [DIM_W-1:0]    i_tex_width,
    input  logic [DIM_W-1:0]    i_tex_height,
    input  logic [DIM_W-1:0]    i_tex_depth,
    input  logic                i_skip_mips,
    input  logic                i_cube_map,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_W-1:0]    o_byte_total,
    output logic                o_format_unknown,
    output logic                o_size_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_HW,
        S_MUL_D,
        S_ACC,
        S_FINISH,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_kind                  r_kind;
    logic [SHIFT_W-1:0]     r_shift;
    logic [DIM_W-1:0]       r_w;
    logic [DIM_W-1:0]       r_h;
    logic [DIM_W-1:0]       r_d;
    logic                   r_skip;
    logic                   r_cube;
    logic [PROD_W-1:0]      r_prod;
    logic [TOTAL_W-1:0]     r_total;

    t_fmt_info              n_info;
    logic [DIM_W-1:0]       n_w_eff;
    logic [DIM_W-1:0]       n_h_eff;
    logic [MUL_A_W-1:0]     n_mul_a;
    logic [MUL_B_W-1:0]     n_mul_b;
    logic [PROD_W-1:0]      n_mul_p;
    logic [TOTAL_W-1:0]     n_level;
    logic [SUM_W-1:0]       n_dim_sum;
    logic [TOTAL_W-1:0]     n_final;

    assign o_ready = (r_state == S_IDLE);
    assign n_info  = fmt_decode(i_pixel_format);

    assign n_w_eff = (r_kind == KIND_BLOCK) ? dim_blocks(r_w) : r_w;
    assign n_h_eff = (r_kind == KIND_BLOCK) ? dim_blocks(r_h) : r_h;

    // shared multiplier
    always_comb begin
        if (r_state == S_MUL_HW) begin
            n_mul_a = MUL_A_W'(n_h_eff);
            n_mul_b = n_w_eff;
        end else begin
            n_mul_a = r_prod[MUL_A_W-1:0];
            n_mul_b = r_d;
        end
        n_mul_p = PROD_W'(n_mul_a) * PROD_W'(n_mul_b);
    end

    assign n_level   = TOTAL_W'(r_prod) << r_shift;
    assign n_dim_sum = SUM_W'(r_w) + SUM_W'(r_h) + SUM_W'(r_d);
    assign n_final   = r_cube ? ((r_total << 2) + (r_total << 1)) : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            o_valid          <= 1'b0;
            o_byte_total     <= '0;
            o_format_unknown <= 1'b0;
            o_size_overflow  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= n_info.kind;
                        r_shift <= n_info.shift;
                        r_w     <= dim_clamp(i_tex_width);
                        r_h     <= dim_clamp(i_tex_height);
                        r_d     <= dim_clamp(i_tex_depth);
                        r_skip  <= i_skip_mips;
                        r_cube  <= i_cube_map;
                        r_total <= '0;
                        if (n_info.kind == KIND_UNKNOWN) begin
                            o_byte_total     <= '0;
                            o_format_unknown <= 1'b1;
                            o_size_overflow  <= 1'b0;
                            o_valid          <= 1'b1;
                            r_state          <= S_OUT;
                        end else begin
                            r_state <= S_MUL_HW;
                        end
                    end
                end
                S_MUL_HW: begin
                    r_prod  <= n_mul_p;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_prod  <= n_mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_total <= r_total + n_level;
                    if (r_skip || (n_dim_sum <= SUM_W'(3))) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_w     <= dim_halve(r_w);
                        r_h     <= dim_halve(r_h);
                        r_d     <= dim_halve(r_d);
                        r_state <= S_MUL_HW;
                    end
                end
                S_FINISH: begin
                    if (n_final[TOTAL_W-1:OUT_W] != '0) begin
                        o_byte_total    <= '1;
                        o_size_overflow <= 1'b1;
                    end else begin
                        o_byte_total    <= n_final[OUT_W-1:0];
                        o_size_overflow <= 1'b0;
                    end
                    o_format_unknown <= 1'b0;
                    o_valid          <= 1'b1;
                    r_state          <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input accepted while a result beat is pending");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_unknown) |-> (o_byte_total == '0 && !o_size_overflow))
        else $error("unknown format beat carries a size");

    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_size_overflow) |-> (o_byte_total == '1))
        else $error("overflow beat not saturated");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer did not leave idle after accept");
`endif

endmodule

// ----- bench/texture_mip_chain_byte_size_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_mip_chain_byte_size_unit_test
// Checks the mip chain byte size unit against a predictor built in the bench.
// Directed textures cover every format class, unknown codes, zero and
// oversized dimensions, mips off, cube maps and saturated totals. Random
// textures then run under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module texture_mip_chain_byte_size_unit_test;
    import tmcbs_pkg::*;

    localparam logic [FMT_W-1:0] FMT_FIRST_UNKNOWN = FMT_TEX8_HI + 5'd1;
    localparam logic [FMT_W-1:0] FMT_LAST_CODE     = '1;
    localparam logic [DIM_W-1:0] DIM_MAX           = '1;
    localparam int               PHASE_TEXTURES    = 170;

    typedef struct {
        logic [OUT_W-1:0] byte_total;
        logic             format_unknown;
        logic             size_overflow;
    } t_footprint;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [FMT_W-1:0] i_pixel_format;
    logic [DIM_W-1:0] i_tex_width;
    logic [DIM_W-1:0] i_tex_height;
    logic [DIM_W-1:0] i_tex_depth;
    logic             i_skip_mips;
    logic             i_cube_map;
    logic             o_valid;
    logic             i_ready;
    logic [OUT_W-1:0] o_byte_total;
    logic             o_format_unknown;
    logic             o_size_overflow;

    t_footprint expected_footprints[$];
    int         send_idle_pct    = 0;
    int         recv_stall_pct   = 0;
    int         error_count      = 0;
    int         textures_sent    = 0;
    int         results_checked  = 0;
    int         unknown_seen     = 0;
    int         saturated_seen   = 0;

    texture_mip_chain_byte_size_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_format   (i_pixel_format),
        .i_tex_width      (i_tex_width),
        .i_tex_height     (i_tex_height),
        .i_tex_depth      (i_tex_depth),
        .i_skip_mips      (i_skip_mips),
        .i_cube_map       (i_cube_map),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_byte_total     (o_byte_total),
        .o_format_unknown (o_format_unknown),
        .o_size_overflow  (o_size_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("texture_mip_chain_byte_size_unit_test NOT OK");
        $finish;
    end

    function automatic t_footprint predict_footprint(
        input logic [FMT_W-1:0] fmt,
        input logic [DIM_W-1:0] w_in,
        input logic [DIM_W-1:0] h_in,
        input logic [DIM_W-1:0] d_in,
        input logic             skip,
        input logic             cube
    );
        t_kind           kind;
        longint unsigned unit;
        longint unsigned lim;
        longint unsigned w, h, d;
        longint unsigned total;
        t_footprint      r;
        kind = KIND_TEXEL;
        unit = 0;
        if (fmt == FMT_DXT1) begin
            kind = KIND_BLOCK;
            unit = 8;
        end else if (fmt <= FMT_DXT5) begin
            kind = KIND_BLOCK;
            unit = 16;
        end else if (fmt <= FMT_RGBA16_HI) begin
            unit = 8;
        end else if (fmt <= FMT_TEX32_HI) begin
            unit = 4;
        end else if (fmt <= FMT_TEX16_HI) begin
            unit = 2;
        end else if (fmt <= FMT_TEX8_HI) begin
            unit = 1;
        end else begin
            kind = KIND_UNKNOWN;
        end
        r.byte_total     = '0;
        r.format_unknown = 1'b0;
        r.size_overflow  = 1'b0;
        if (kind == KIND_UNKNOWN) begin
            r.format_unknown = 1'b1;
            return r;
        end
        lim = longint'(1) << MAX_DIM_LOG2;
        w = (w_in > lim) ? lim : w_in;
        h = (h_in > lim) ? lim : h_in;
        d = (d_in > lim) ? lim : d_in;
        total = 0;
        forever begin
            if (kind == KIND_TEXEL)
                total += unit * d * h * w;
            else
                total += unit * d * ((h + 3) >> 2) * ((w + 3) >> 2);
            if (skip || (w + h + d <= 3))
                break;
            w = ((w >> 1) == 0) ? 1 : (w >> 1);
            h = ((h >> 1) == 0) ? 1 : (h >> 1);
            d = ((d >> 1) == 0) ? 1 : (d >> 1);
        end
        if (cube)
            total *= 6;
        if (total > 64'hFFFF_FFFF) begin
            r.byte_total    = '1;
            r.size_overflow = 1'b1;
        end else begin
            r.byte_total = total[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(9))
            0, 1, 2, 3: return DIM_W'($urandom_range(64, 1));
            4, 5:       return DIM_W'($urandom_range(DIM_MAX));
            6:          return DIM_W'(1) << $urandom_range(MAX_DIM_LOG2);
            7:          return DIM_W'($urandom_range(DIM_MAX, DIM_LIMIT));
            default:    return DIM_W'($urandom_range(1));
        endcase
    endfunction

    task automatic send_texture(
        input logic [FMT_W-1:0] fmt,
        input logic [DIM_W-1:0] w,
        input logic [DIM_W-1:0] h,
        input logic [DIM_W-1:0] d,
        input logic             skip,
        input logic             cube
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pixel_format <= fmt;
        i_tex_width    <= w;
        i_tex_height   <= h;
        i_tex_depth    <= d;
        i_skip_mips    <= skip;
        i_cube_map     <= cube;
        do @(posedge i_clk); while (!o_ready);
        expected_footprints.push_back(predict_footprint(fmt, w, h, d, skip, cube));
        textures_sent++;
    endtask

    task automatic test_format_codes();
        logic [FMT_W-1:0] codes[$];
        codes = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_RGBA16_LO, FMT_RGBA16_HI,
                  FMT_TEX32_LO, FMT_TEX32_HI, FMT_TEX16_LO, FMT_TEX16_HI,
                  FMT_TEX8_LO, FMT_TEX8_HI, FMT_FIRST_UNKNOWN, FMT_LAST_CODE};
        foreach (codes[i])
            send_texture(codes[i], 14'd37, 14'd19, 14'd3, 1'b0, 1'b0);
    endtask

    task automatic test_dimension_extremes();
        send_texture(FMT_TEX32_LO,  14'd1,    14'd1,    14'd1,    1'b0, 1'b0);
        send_texture(FMT_DXT1,      14'd1,    14'd1,    14'd1,    1'b0, 1'b0);
        send_texture(FMT_DXT5,      14'd0,    14'd0,    14'd0,    1'b0, 1'b0);
        send_texture(FMT_TEX8_LO,   14'd0,    14'd5,    14'd1,    1'b0, 1'b0);
        send_texture(FMT_TEX32_LO,  DIM_LIMIT, DIM_LIMIT, 14'd1,  1'b0, 1'b0);
        send_texture(FMT_RGBA16_LO, DIM_MAX,  DIM_MAX,  DIM_MAX,  1'b0, 1'b1);
        send_texture(FMT_TEX8_LO,   DIM_LIMIT + 14'd1, 14'd1, 14'd1, 1'b0, 1'b0);
        send_texture(FMT_DXT3,      DIM_LIMIT, 14'd4,   14'd1,    1'b1, 1'b1);
        send_texture(FMT_TEX16_LO,  14'd3,    14'd2,    14'd1,    1'b0, 1'b1);
        send_texture(FMT_DXT1,      DIM_LIMIT, DIM_LIMIT, DIM_LIMIT, 1'b0, 1'b0);
        send_texture(FMT_TEX8_HI,   14'd4096, 14'd4096, 14'd256,  1'b1, 1'b0);
        send_texture(FMT_TEX8_HI,   14'd4096, 14'd4096, 14'd255,  1'b1, 1'b0);
        send_texture(FMT_TEX32_HI,  DIM_MAX,  14'd1,    14'd1,    1'b0, 1'b0);
    endtask

    task automatic test_random_textures(input int idle_pct, input int stall_pct,
                                        input int count);
        logic [FMT_W-1:0] fmt;
        logic [DIM_W-1:0] d;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            fmt = ($urandom_range(4) == 0) ? FMT_W'($urandom_range(FMT_LAST_CODE))
                                           : FMT_W'($urandom_range(FMT_TEX8_HI));
            d   = $urandom_range(1) ? 14'd1 : pick_dim();
            send_texture(fmt, pick_dim(), pick_dim(), d,
                         ($urandom_range(3) == 0), 1'($urandom_range(1)));
        end
    endtask

    initial begin : result_checker
        t_footprint want;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_footprints.size() == 0) begin
                    $error("result beat with no texture pending: total %h", o_byte_total);
                    error_count++;
                end else begin
                    want = expected_footprints.pop_front();
                    results_checked++;
                    if (want.format_unknown)
                        unknown_seen++;
                    if (want.size_overflow)
                        saturated_seen++;
                    if (o_byte_total !== want.byte_total) begin
                        $error("byte_total: expected %h, got %h",
                               want.byte_total, o_byte_total);
                        error_count++;
                    end
                    if (o_format_unknown !== want.format_unknown) begin
                        $error("format_unknown: expected %b, got %b",
                               want.format_unknown, o_format_unknown);
                        error_count++;
                    end
                    if (o_size_overflow !== want.size_overflow) begin
                        $error("size_overflow: expected %b, got %b",
                               want.size_overflow, o_size_overflow);
                        error_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_pixel_format <= '0;
        i_tex_width    <= '0;
        i_tex_height   <= '0;
        i_tex_depth    <= '0;
        i_skip_mips    <= 1'b0;
        i_cube_map     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_format_codes();
        test_dimension_extremes();
        test_random_textures(0, 0, PHASE_TEXTURES);
        test_random_textures(61, 0, PHASE_TEXTURES);
        test_random_textures(0, 61, PHASE_TEXTURES);
        test_random_textures(7, 7, PHASE_TEXTURES);

        // drop valid and drain
        i_valid <= 1'b0;
        while (expected_footprints.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (expected_footprints.size() != 0) begin
            $error("%0d results never arrived", expected_footprints.size());
            error_count++;
        end
        $display("sent %0d textures, checked %0d results", textures_sent, results_checked);
        $display("of those, %0d unknown formats and %0d saturated totals",
                 unknown_seen, saturated_seen);
        if (error_count == 0)
            $display("texture_mip_chain_byte_size_unit_test OK");
        else
            $display("texture_mip_chain_byte_size_unit_test NOT OK");
        $finish;
    end

endmodule
